/* hw/rtl/biq_pkg.sv */
// Shared constants and types for the biquad low-pass filter.
// No dependencies.
`default_nettype none

package biq_pkg;

  localparam int SAMPLE_W_DEF = 16;
  localparam int COEF_W_DEF   = 20;
  localparam int DELAY_W_DEF  = 40;
  localparam int GAIN_W       = 28;

  // fixed-point fraction bits
  localparam int COEF_FRAC  = 16;
  localparam int DELAY_FRAC = 8;
  localparam int PRIME_SH   = DELAY_FRAC;
  localparam int W_SH       = COEF_FRAC;
  localparam int Y_SH       = COEF_FRAC + DELAY_FRAC;

  localparam int          CFG_IDX_W  = 3;
  localparam logic [2:0]  REG_BYPASS = 3'd0;
  localparam logic [2:0]  REG_B0     = 3'd1;
  localparam logic [2:0]  REG_B1     = 3'd2;
  localparam logic [2:0]  REG_B2     = 3'd3;
  localparam logic [2:0]  REG_A1     = 3'd4;
  localparam logic [2:0]  REG_A2     = 3'd5;
  localparam logic [2:0]  REG_GAIN   = 3'd6;

  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

  // product waiting to be accumulated
  typedef struct packed {
    logic vld;
    logic sub;
    logic hi;
  } biq_pend_t;

endpackage

`default_nettype wire

/* hw/rtl/biquad_lowpass_filter.sv */
// Direct Form II biquad low-pass filter over one shared multiplier.
// Depends on biq_pkg.
//
// channel  direction  handshake                 payload
// in_      input      in_valid / in_ready       in_sample_in
// out_     output     out_valid / out_ready     out_filtered_out
// cfg_     input      cfg_wen                   cfg_idx, cfg_wdata
//
// Bypass: one item per cycle while the output is free. Filter: primes on
// the first item after reset. Each of the five products per item is split
// into two half-width partial products through the one registered
// multiplier. Reset is synchronous (rst_n low) and clears no memory. A
// result waits in the output register while out_ready is low; a filter
// item may be taken meanwhile and stalls before its result.
`default_nettype none

module biquad_lowpass_filter
  import biq_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_W_DEF,
  parameter int COEF_WIDTH   = COEF_W_DEF,
  parameter int DELAY_WIDTH  = DELAY_W_DEF,
  localparam int CFG_DW      = (COEF_WIDTH > GAIN_W) ? COEF_WIDTH : GAIN_W
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample_in,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic signed [SAMPLE_WIDTH-1:0] out_filtered_out,
  input  wire logic                           cfg_wen,
  input  wire logic [CFG_IDX_W-1:0]           cfg_idx,
  input  wire logic [CFG_DW-1:0]              cfg_wdata
);

  localparam int AW    = (DELAY_WIDTH > SAMPLE_WIDTH) ? DELAY_WIDTH : SAMPLE_WIDTH;
  localparam int H     = (AW + 1) / 2;
  localparam int BW    = (COEF_WIDTH > GAIN_W + 1) ? COEF_WIDTH : GAIN_W + 1;
  localparam int PW    = H + 1 + BW;
  localparam int T1    = AW + BW;
  localparam int T2    = SAMPLE_WIDTH + Y_SH;
  localparam int ACC_W = ((T1 > T2) ? T1 : T2) + 2;

  localparam logic [ACC_W-1:0] ONE = {{(ACC_W-1){1'b0}}, 1'b1};
  localparam logic signed [ACC_W-1:0] HALF_P = signed'(ONE << (PRIME_SH - 1));
  localparam logic signed [ACC_W-1:0] HALF_W = signed'(ONE << (W_SH - 1));
  localparam logic signed [ACC_W-1:0] HALF_Y = signed'(ONE << (Y_SH - 1));
  localparam logic signed [ACC_W-1:0] D_MAX  = signed'((ONE << (DELAY_WIDTH-1)) - ONE);
  localparam logic signed [ACC_W-1:0] D_MIN  = ~D_MAX;
  localparam logic signed [ACC_W-1:0] S_MAX  = signed'((ONE << (SAMPLE_WIDTH-1)) - ONE);
  localparam logic signed [ACC_W-1:0] S_MIN  = ~S_MAX;

  typedef enum logic [2:0] {
    S_IDLE, S_PRIME, S_PSAT, S_FB, S_WSAT, S_FF, S_YSAT
  } state_t;

  state_t                          state_r;
  logic [2:0]                      op_r;
  biq_pend_t                       pend_r;
  logic                            primed_r;
  logic                            bypass_r;
  logic signed [COEF_WIDTH-1:0]    b0_r, b1_r, b2_r, a1_r, a2_r;
  logic [GAIN_W-1:0]               gain_r;
  logic signed [SAMPLE_WIDTH-1:0]  samp_r;
  logic signed [DELAY_WIDTH-1:0]   d1_r, d2_r, w0_r;
  logic signed [ACC_W-1:0]         acc_r;
  logic signed [PW-1:0]            prod_r;
  logic                            out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0]  out_data_r;

  logic                            out_free;
  logic signed [AW-1:0]            a_full;
  logic signed [BW-1:0]            mul_b;
  logic signed [H:0]               mul_a;
  logic signed [PW-1:0]            mul_p;
  logic signed [ACC_W-1:0]         addend;
  logic signed [ACC_W-1:0]         acc_sum;
  logic signed [ACC_W-1:0]         rnd_p, rnd_w, rnd_y;
  logic signed [DELAY_WIDTH-1:0]   sat_p, sat_w;
  logic signed [SAMPLE_WIDTH-1:0]  sat_y;

  assign out_free         = !out_valid_r || out_ready;
  assign in_ready         = (state_r == S_IDLE) && (!bypass_r || out_free);
  assign out_valid        = out_valid_r;
  assign out_filtered_out = out_data_r;
  assign mul_p            = mul_a * mul_b;

  // operand select
  always_comb begin
    a_full = AW'(samp_r);
    mul_b  = BW'(signed'({1'b0, gain_r}));
    case (state_r)
      S_FB: begin
        a_full = op_r[1] ? AW'(d2_r) : AW'(d1_r);
        mul_b  = op_r[1] ? BW'(a2_r) : BW'(a1_r);
      end
      S_FF: begin
        case (op_r[2:1])
          2'd0: begin
            a_full = AW'(w0_r);
            mul_b  = BW'(b0_r);
          end
          2'd1: begin
            a_full = AW'(d1_r);
            mul_b  = BW'(b1_r);
          end
          default: begin
            a_full = AW'(d2_r);
            mul_b  = BW'(b2_r);
          end
        endcase
      end
      default: ;
    endcase
    if (op_r[0]) begin
      mul_a = (H+1)'(signed'(a_full[AW-1:H]));
    end else begin
      mul_a = signed'({1'b0, a_full[H-1:0]});
    end
  end

  // accumulate, round, saturate
  always_comb begin
    addend = ACC_W'(prod_r);
    if (pend_r.hi) begin
      addend = addend <<< H;
    end
    if (pend_r.sub) begin
      addend = -addend;
    end
    acc_sum = pend_r.vld ? (acc_r + addend) : acc_r;

    rnd_p = (acc_r + HALF_P) >>> PRIME_SH;
    rnd_w = (acc_r + HALF_W) >>> W_SH;
    rnd_y = (acc_r + HALF_Y) >>> Y_SH;

    if (rnd_p > D_MAX)      sat_p = DELAY_WIDTH'(D_MAX);
    else if (rnd_p < D_MIN) sat_p = DELAY_WIDTH'(D_MIN);
    else                    sat_p = DELAY_WIDTH'(rnd_p);

    if (rnd_w > D_MAX)      sat_w = DELAY_WIDTH'(D_MAX);
    else if (rnd_w < D_MIN) sat_w = DELAY_WIDTH'(D_MIN);
    else                    sat_w = DELAY_WIDTH'(rnd_w);

    if (rnd_y > S_MAX)      sat_y = SAMPLE_WIDTH'(S_MAX);
    else if (rnd_y < S_MIN) sat_y = SAMPLE_WIDTH'(S_MIN);
    else                    sat_y = SAMPLE_WIDTH'(rnd_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= '0;
      pend_r      <= '0;
      primed_r    <= 1'b0;
      bypass_r    <= 1'b1;
      b0_r        <= '0;
      b1_r        <= '0;
      b2_r        <= '0;
      a1_r        <= '0;
      a2_r        <= '0;
      gain_r      <= GAIN_RESET;
      d1_r        <= '0;
      d2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        case (cfg_idx)
          REG_BYPASS: bypass_r <= cfg_wdata[0];
          REG_B0:     b0_r     <= signed'(cfg_wdata[COEF_WIDTH-1:0]);
          REG_B1:     b1_r     <= signed'(cfg_wdata[COEF_WIDTH-1:0]);
          REG_B2:     b2_r     <= signed'(cfg_wdata[COEF_WIDTH-1:0]);
          REG_A1:     a1_r     <= signed'(cfg_wdata[COEF_WIDTH-1:0]);
          REG_A2:     a2_r     <= signed'(cfg_wdata[COEF_WIDTH-1:0]);
          REG_GAIN:   gain_r   <= cfg_wdata[GAIN_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      prod_r     <= mul_p;
      pend_r.vld <= 1'b0;
      pend_r.sub <= (state_r == S_FB);
      pend_r.hi  <= op_r[0];
      acc_r      <= acc_sum;

      case (state_r)
        S_IDLE: begin
          op_r <= '0;
          if (in_valid && in_ready) begin
            samp_r <= in_sample_in;
            if (bypass_r) begin
              out_data_r  <= in_sample_in;
              out_valid_r <= 1'b1;
            end else if (primed_r) begin
              acc_r   <= ACC_W'(in_sample_in) <<< Y_SH;
              state_r <= S_FB;
            end else begin
              acc_r   <= '0;
              state_r <= S_PRIME;
            end
          end
        end
        S_PRIME: begin
          pend_r.vld <= 1'b1;
          op_r       <= op_r + 3'd1;
          if (op_r == 3'd1) begin
            state_r <= S_PSAT;
          end
        end
        S_PSAT: begin
          op_r <= '0;
          if (!pend_r.vld) begin
            d1_r     <= sat_p;
            d2_r     <= sat_p;
            primed_r <= 1'b1;
            acc_r    <= ACC_W'(samp_r) <<< Y_SH;
            state_r  <= S_FB;
          end
        end
        S_FB: begin
          pend_r.vld <= 1'b1;
          op_r       <= op_r + 3'd1;
          if (op_r == 3'd3) begin
            state_r <= S_WSAT;
          end
        end
        S_WSAT: begin
          op_r <= '0;
          if (!pend_r.vld) begin
            w0_r    <= sat_w;
            acc_r   <= '0;
            state_r <= S_FF;
          end
        end
        S_FF: begin
          pend_r.vld <= 1'b1;
          op_r       <= op_r + 3'd1;
          if (op_r == 3'd5) begin
            state_r <= S_YSAT;
          end
        end
        S_YSAT: begin
          op_r <= '0;
          if (!pend_r.vld && out_free) begin
            out_data_r  <= sat_y;
            out_valid_r <= 1'b1;
            d2_r        <= d1_r;
            d1_r        <= w0_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for biquad_lowpass_filter: directed and random samples
// across bypass, priming, saturation and coefficient changes, checked per item.
// Depends on biq_pkg and the biquad_lowpass_filter RTL.
module tb;
  import biq_pkg::*;

  localparam int SW           = SAMPLE_W_DEF;
  localparam int CW           = COEF_W_DEF;
  localparam int DW           = DELAY_W_DEF;
  localparam int ITEMS        = 1700;
  localparam int CALM_TAIL    = 150;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 40;
  localparam int COEF_MAX     = (1 << (CW - 1)) - 1;
  localparam int COEF_MIN     = -(1 << (CW - 1));
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = '1;

  class filter_scoreboard;
    bit                   bypass;
    logic signed [CW-1:0] b0, b1, b2, a1, a2;
    logic [GAIN_W-1:0]    gain;
    logic signed [DW-1:0] d1, d2;
    bit                   primed;
    logic signed [SW-1:0] filtered_due[$];
    int                   errors;

    function new();
      bypass = 1'b1;
      b0 = '0; b1 = '0; b2 = '0; a1 = '0; a2 = '0;
      gain = GAIN_RESET;
      d1 = '0; d2 = '0;
      primed = 1'b0;
      errors = 0;
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] data);
      case (idx)
        REG_BYPASS: bypass = data[0];
        REG_B0:     b0 = data[CW-1:0];
        REG_B1:     b1 = data[CW-1:0];
        REG_B2:     b2 = data[CW-1:0];
        REG_A1:     a1 = data[CW-1:0];
        REG_A2:     a2 = data[CW-1:0];
        REG_GAIN:   gain = data;
        default: ;
      endcase
    endfunction

    // round half up, then arithmetic shift
    function logic signed [95:0] round_sh(logic signed [95:0] x, int n);
      return (x + (96'sd1 <<< (n - 1))) >>> n;
    endfunction

    function logic signed [95:0] clamp(logic signed [95:0] x, int w);
      logic signed [95:0] hi, lo;
      hi = (96'sd1 <<< (w - 1)) - 96'sd1;
      lo = -hi - 96'sd1;
      if (x > hi) return hi;
      if (x < lo) return lo;
      return x;
    endfunction

    function void note_sample(logic signed [SW-1:0] s);
      logic signed [95:0] xs, pg, c0, c1, c2, f1, f2, e1, e2, acc, w0, y;
      if (bypass) begin
        filtered_due.push_back(s);
        return;
      end
      xs = 96'(s);
      pg = {68'd0, gain};
      if (!primed) begin
        acc = clamp(round_sh(xs * pg, PRIME_SH), DW);
        d1 = acc[DW-1:0];
        d2 = acc[DW-1:0];
        primed = 1'b1;
      end
      c0 = 96'(b0); c1 = 96'(b1); c2 = 96'(b2); f1 = 96'(a1); f2 = 96'(a2);
      e1 = 96'(d1); e2 = 96'(d2);
      acc = (xs <<< Y_SH) - e1 * f1 - e2 * f2;
      w0 = clamp(round_sh(acc, W_SH), DW);
      acc = w0 * c0 + e1 * c1 + e2 * c2;
      y = clamp(round_sh(acc, Y_SH), SW);
      d2 = d1;
      d1 = w0[DW-1:0];
      filtered_due.push_back(y[SW-1:0]);
    endfunction

    function void check_result(logic signed [SW-1:0] got);
      logic signed [SW-1:0] want;
      if (filtered_due.size() == 0) begin
        errors++;
        $display("%0t: filtered_out expected none got %0d", $time, got);
        return;
      end
      want = filtered_due.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: filtered_out expected %0d got %0d", $time, want, got);
      end
    endfunction

    function int pending();
      return filtered_due.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [SW-1:0]     in_sample_in = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [SW-1:0]     out_filtered_out;
  logic                     cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx = '0;
  logic [GAIN_W-1:0]        cfg_wdata = '0;

  filter_scoreboard sb;
  bit idle_on = 1'b1;
  int sent = 0;
  int stall_left = 0;
  int quiet = 0;

  int set_b0[3]   = '{4425, 237, 19196};
  int set_a1[3]   = '{-74907, -119454, 0};
  int set_a2[3]   = '{27053, 54866, 11247};
  int set_gain[3] = '{242890, 4513468, 55937};

  biquad_lowpass_filter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_in     (in_sample_in),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_filtered_out (out_filtered_out),
    .cfg_wen          (cfg_wen),
    .cfg_idx          (cfg_idx),
    .cfg_wdata        (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_filtered_out);
    if (stall_left != 0) stall_left--;
    else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
    out_ready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic send_sample(input logic signed [SW-1:0] s);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
    sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
    cfg_wen <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.apply_write(idx, data);
  endtask

  // junk above the coefficient width must be dropped
  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input int v);
    logic [GAIN_W-1:0] data;
    data = GAIN_W'($urandom());
    data[CW-1:0] = v[CW-1:0];
    write_reg(idx, data);
  endtask

  task automatic write_bypass(input bit on);
    logic [GAIN_W-1:0] data;
    data = GAIN_W'($urandom());
    data[0] = on;
    write_reg(REG_BYPASS, data);
  endtask

  task automatic write_filter(input int c0, input int c1, input int c2, input int f1,
                              input int f2, input logic [GAIN_W-1:0] g);
    write_coef(REG_B0, c0);
    write_coef(REG_B1, c1);
    write_coef(REG_B2, c2);
    write_coef(REG_A1, f1);
    write_coef(REG_A2, f2);
    write_reg(REG_GAIN, g);
    write_bypass(1'b0);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 2))
      0: return COEF_MIN;
      1: return COEF_MAX;
      default: return 0;
    endcase
  endfunction

  function automatic logic signed [SW-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      0: v = $urandom_range(0, 1) ? (1 << (SW - 1)) - 1 : -(1 << (SW - 1));
      1, 2, 3: v = int'($urandom_range(0, 511)) - 256;
      default: v = $urandom();
    endcase
    return v[SW-1:0];
  endfunction

  task automatic configure(input int kind);
    int k;
    int c0;
    k = $urandom_range(0, 2);
    case (kind)
      0: write_bypass(1'b1);
      1: write_filter(set_b0[k], 2 * set_b0[k], set_b0[k], set_a1[k], set_a2[k],
                      GAIN_W'(set_gain[k]));
      2: begin
        c0 = $urandom_range(0, 8192);
        write_filter(c0, 2 * c0, c0, set_a1[k], set_a2[k], GAIN_W'($urandom()));
      end
      3: write_filter($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                      GAIN_W'($urandom()));
      4: write_filter(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                      pick_extreme(), $urandom_range(0, 1) ? GAIN_MAX : '0);
      default: begin
        // tweak while running, no re-prime
        write_reg(REG_NONE, GAIN_W'($urandom()));
        case ($urandom_range(0, 5))
          0: write_coef(REG_B0, $urandom());
          1: write_coef(REG_B1, $urandom());
          2: write_coef(REG_B2, $urandom());
          3: write_coef(REG_A1, $urandom());
          4: write_coef(REG_A2, $urandom());
          default: write_reg(REG_GAIN, GAIN_W'($urandom()));
        endcase
      end
    endcase
    cfg_wen <= 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config is bypass
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'shffff);
    send_sample(16'sh0001);
    send_sample(16'sh5555);
    send_sample(16'shaaaa);

    // first filtered item primes the delay line
    settle();
    write_reg(REG_NONE, '1);
    write_filter(set_b0[0], 2 * set_b0[0], set_b0[0], set_a1[0], set_a2[0],
                 GAIN_W'(set_gain[0]));
    cfg_wen <= 1'b0;
    send_sample(16'sh7fff);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);
    send_sample(16'sh0001);
    send_sample(16'shffff);

    // saturation both ways
    settle();
    write_filter(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, GAIN_MAX);
    cfg_wen <= 1'b0;
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    settle();
    write_filter(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MAX, '0);
    cfg_wen <= 1'b0;
    send_sample(16'sh7fff);
    send_sample(16'sh8000);
    send_sample(16'sh0000);

    // bypass keeps the delay line
    settle();
    write_bypass(1'b1);
    cfg_wen <= 1'b0;
    send_sample(16'sh0064);
    settle();
    write_filter(set_b0[1], 2 * set_b0[1], set_b0[1], set_a1[1], set_a2[1],
                 GAIN_W'(set_gain[1]));
    cfg_wen <= 1'b0;
    send_sample(16'sh0400);
    send_sample(16'shfc00);

    while (sent < ITEMS) begin
      settle();
      configure($urandom_range(0, 5));
      idle_on = ($urandom_range(0, 3) != 0) && (sent < ITEMS - CALM_TAIL);
      repeat ($urandom_range(15, 60)) begin
        if (sent >= ITEMS - CALM_TAIL) idle_on = 1'b0;
        send_sample(pick_sample());
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

/* sim.f */
hw/rtl/biq_pkg.sv
hw/rtl/biquad_lowpass_filter.sv
tb/tb.sv
